// File: rtl/core/gpc_pkg.sv
// Shared types and request codes for the GPIO port with pin change interrupt.
package gpc_pkg;

  localparam int unsigned PortW = 8;

  // Request codes
  localparam logic [2:0] ReqPortWr = 3'd0;
  localparam logic [2:0] ReqPortRd = 3'd1;
  localparam logic [2:0] ReqDirWr  = 3'd2;
  localparam logic [2:0] ReqDirRd  = 3'd3;
  localparam logic [2:0] ReqPinEvt = 3'd4;

  // Configuration register indexes
  localparam logic CfgDrivenPinMask = 1'b0;
  localparam logic CfgIntEdgeRising = 1'b1;

  localparam logic [PortW-1:0] ChangeMask = 8'hf0;
  localparam logic [PortW-1:0] DirReset   = 8'hff;

  typedef struct packed {
    logic [2:0]       req_type;
    logic [PortW-1:0] wdata;
    logic [2:0]       bit_index;
    logic [PortW-1:0] pin_levels;
  } req_t;

  typedef struct packed {
    logic [PortW-1:0] read_data;
    logic             ext_int_flag;
    logic             change_int_flag;
  } rsp_t;

  typedef struct packed {
    logic [PortW-1:0] port_bits;
    logic [PortW-1:0] direction_bits;
    logic [PortW-1:0] driven_pin_mask;
    logic             int_edge_rising;
  } state_t;

  typedef struct packed {
    logic             upd;
    logic [PortW-1:0] port_bits;
    logic [PortW-1:0] direction_bits;
  } state_upd_t;

endpackage

// File: rtl/core/gpc_regs.sv
// Port, direction and configuration registers.
module gpc_regs (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic                cfg_idx_i,
  input  logic [7:0]          cfg_wdata_i,
  input  gpc_pkg::state_upd_t upd_i,
  output gpc_pkg::state_t     state_o
);
  import gpc_pkg::*;

  logic [PortW-1:0] port_q, dir_q, drv_q;
  logic             edge_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      port_q <= '0;
      dir_q  <= DirReset;
    end else if (upd_i.upd) begin
      port_q <= upd_i.port_bits;
      dir_q  <= upd_i.direction_bits;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      drv_q  <= '0;
      edge_q <= 1'b1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgDrivenPinMask: drv_q  <= cfg_wdata_i;
        CfgIntEdgeRising: edge_q <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  assign state_o = '{port_bits:       port_q,
                     direction_bits:  dir_q,
                     driven_pin_mask: drv_q,
                     int_edge_rising: edge_q};

endmodule

// File: rtl/core/gpc_logic.sv
// Request decode, next port/direction value and interrupt flag logic.
module gpc_logic #(
  parameter int unsigned PIN_COUNT = 8
) (
  input  gpc_pkg::req_t       req_i,
  input  gpc_pkg::state_t     state_i,
  output logic [7:0]          port_d_o,
  output logic [7:0]          dir_d_o,
  output gpc_pkg::rsp_t       rsp_o
);
  import gpc_pkg::*;

  localparam logic [PortW-1:0] PinMask = PortW'((16'(1) << PIN_COUNT) - 16'(1));

  logic [PortW-1:0] old_port, dir, drv, sampled, diff, pin_sel;
  logic             check;

  always_comb begin
    old_port = state_i.port_bits;
    dir      = state_i.direction_bits;
    drv      = state_i.driven_pin_mask & PinMask;
    sampled  = (req_i.pin_levels | (old_port & ~dir)) & drv;
    pin_sel  = PortW'(1) << req_i.bit_index;
    port_d_o = old_port;
    dir_d_o  = dir;
    check    = 1'b0;
    rsp_o.read_data = old_port;

    unique case (req_i.req_type)
      ReqPortWr: begin
        port_d_o = ((req_i.wdata & ~dir) | (old_port & dir)) & PinMask;
        rsp_o.read_data = port_d_o;
      end
      ReqPortRd: begin
        port_d_o = ((old_port & ~drv) | sampled) & PinMask;
        rsp_o.read_data = port_d_o;
        check = 1'b1;
      end
      ReqDirWr: begin
        dir_d_o = req_i.wdata;
        rsp_o.read_data = req_i.wdata;
      end
      ReqDirRd: begin
        rsp_o.read_data = dir;
      end
      ReqPinEvt: begin
        // drop events on pins the port does not have
        if (32'(req_i.bit_index) < PIN_COUNT) begin
          if (req_i.wdata[0]) port_d_o = (old_port | pin_sel) & PinMask;
          else                port_d_o = old_port & ~pin_sel & PinMask;
        end
        rsp_o.read_data = port_d_o;
        check = 1'b1;
      end
      default: ;
    endcase

    diff = old_port ^ port_d_o;
    rsp_o.ext_int_flag    = check & diff[0] & (state_i.int_edge_rising ^ old_port[0]);
    rsp_o.change_int_flag = check & (|(diff & ChangeMask));
  end

endmodule

// File: rtl/core/gpio_port_with_pin_change_interrupt.sv
// Top level: request register, port logic and result register.
//
//   Channel  | Dir | Fields (low bit up)
//   s_axis   | in  | tuser: req_type[2:0]; tdata: wdata[7:0] bit_index[10:8] pin_levels[18:11]
//   m_axis   | out | tdata: read_data[7:0] ext_int_flag[8] change_int_flag[9]
//   cfg      | in  | idx 0 driven_pin_mask, idx 1 int_edge_rising
//
// One request per cycle while the result is taken or the result register is
// empty; the edge that accepts a request loads the request register, and the
// request then moves through the port logic into the result register once that
// register is free or being taken; the port and direction registers update at
// the same edge. Reset clears both valid bits, the port to 0 and the direction
// to all inputs. A stalled result holds the request register; requests keep
// flowing while the result is taken in the same cycle.
module gpio_port_with_pin_change_interrupt #(
  parameter int unsigned PIN_COUNT = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [23:0] s_axis_tdata_i,  // wdata, bit_index, pin_levels, zero pad
  input  logic [2:0]  s_axis_tuser_i,  // req_type
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o,  // read_data, ext_int_flag, change_int_flag, zero pad
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [7:0]  cfg_wdata_i
);
  import gpc_pkg::*;

  logic       in_valid_q, out_valid_q, adv;
  req_t       req_q;
  rsp_t       rsp_d, rsp_q;
  state_t     state;
  state_upd_t upd;
  logic [7:0] port_d, dir_d;

  assign adv             = in_valid_q & (~out_valid_q | m_axis_tready_i);
  assign s_axis_tready_o = ~in_valid_q | adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_axis_tready_o) in_valid_q <= s_axis_tvalid_i;
      if (adv)                  out_valid_q <= 1'b1;
      else if (m_axis_tready_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      req_q <= '{req_type:   s_axis_tuser_i,
                 wdata:      s_axis_tdata_i[7:0],
                 bit_index:  s_axis_tdata_i[10:8],
                 pin_levels: s_axis_tdata_i[18:11]};
    end
    if (adv) rsp_q <= rsp_d;
  end

  gpc_logic #(
    .PIN_COUNT(PIN_COUNT)
  ) u_logic (
    .req_i   (req_q),
    .state_i (state),
    .port_d_o(port_d),
    .dir_d_o (dir_d),
    .rsp_o   (rsp_d)
  );

  assign upd = '{upd: adv, port_bits: port_d, direction_bits: dir_d};

  gpc_regs u_regs (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .upd_i      (upd),
    .state_o    (state)
  );

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {6'd0, rsp_q.change_int_flag, rsp_q.ext_int_flag, rsp_q.read_data};

endmodule

// File: test/tb_top.sv
// Self-checking testbench for the GPIO port with pin change interrupt.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import gpc_pkg::*;

  localparam int unsigned IdleLimit   = 3000;
  localparam int unsigned DrainCycles = 6;
  localparam int unsigned LongHold    = 300;
  localparam int unsigned RandPhases  = 6;
  localparam int unsigned PhaseItems  = 230;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [23:0] s_axis_tdata_i = '0;
  logic [2:0]  s_axis_tuser_i = '0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [15:0] m_axis_tdata_o;
  logic        cfg_we_i = 1'b0;
  logic        cfg_idx_i = 1'b0;
  logic [7:0]  cfg_wdata_i = '0;

  gpio_port_with_pin_change_interrupt i_dut (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid_i,
    .s_axis_tready_o,
    .s_axis_tdata_i,
    .s_axis_tuser_i,
    .m_axis_tvalid_o,
    .m_axis_tready_i,
    .m_axis_tdata_o,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_wdata_i
  );

  always #5ns clk_i = ~clk_i;

  // Shadow of the port state and its configuration
  logic [PortW-1:0] shadow_port = '0;
  logic [PortW-1:0] shadow_dir  = DirReset;
  logic [PortW-1:0] shadow_drive_mask = '0;
  logic             shadow_rise_edge  = 1'b1;

  req_t queued_reqs[$];
  rsp_t awaited_rsps[$];
  int   errors = 0;
  int   reqs_taken = 0;
  int   rsps_taken = 0;
  int   idle_cycles = 0;

  function automatic rsp_t predict_access(req_t r);
    rsp_t             res;
    logic [PortW-1:0] prev;
    logic [PortW-1:0] sampled;
    logic [PortW-1:0] diff;
    logic             edge_check;
    prev = shadow_port;
    edge_check = 1'b0;
    res.read_data = shadow_port;
    case (r.req_type)
      ReqPortWr: begin
        shadow_port = (r.wdata & ~shadow_dir) | (shadow_port & shadow_dir);
      end
      ReqPortRd: begin
        sampled = (r.pin_levels | (shadow_port & ~shadow_dir)) & shadow_drive_mask;
        shadow_port = (shadow_port & ~shadow_drive_mask) | sampled;
        edge_check = 1'b1;
      end
      ReqDirWr: begin
        shadow_dir = r.wdata;
      end
      ReqPinEvt: begin
        shadow_port[r.bit_index] = r.wdata[0];
        edge_check = 1'b1;
      end
      default: ;
    endcase
    if (r.req_type == ReqDirWr || r.req_type == ReqDirRd) begin
      res.read_data = shadow_dir;
    end else begin
      res.read_data = shadow_port;
    end
    diff = prev ^ shadow_port;
    res.ext_int_flag    = edge_check & diff[0] & (shadow_rise_edge ^ prev[0]);
    res.change_int_flag = edge_check & (|(diff & ChangeMask));
    return res;
  endfunction

  // Mostly short gaps, a few long ones, and calm stretches with none
  function automatic int unsigned pick_gap(int count);
    int unsigned r;
    r = $urandom_range(0, 99);
    if ((count / 150) % 4 == 3) return 0;
    if (r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 50);
  endfunction

  // Request driver
  always @(posedge clk_i) begin : drv
    int unsigned send_gap;
    req_t        cur;
    logic        holding;
    if (rst_ni) begin
      holding = s_axis_tvalid_i && !s_axis_tready_o;
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        cur = {s_axis_tuser_i, s_axis_tdata_i[7:0], s_axis_tdata_i[10:8],
               s_axis_tdata_i[18:11]};
        awaited_rsps.push_back(predict_access(cur));
        reqs_taken++;
        send_gap = pick_gap(reqs_taken);
      end
      if (!holding) begin
        if (send_gap > 0) begin
          send_gap--;
          s_axis_tvalid_i <= 1'b0;
        end else if (queued_reqs.size() > 0) begin
          cur = queued_reqs.pop_front();
          s_axis_tuser_i  <= cur.req_type;
          s_axis_tdata_i  <= {5'b0, cur.pin_levels, cur.bit_index, cur.wdata};
          s_axis_tvalid_i <= 1'b1;
        end else begin
          s_axis_tvalid_i <= 1'b0;
        end
      end
    end
  end

  // Result monitor and receiver back-pressure
  always @(posedge clk_i) begin : mon
    int unsigned hold_cnt;
    bit          long_hold_done;
    rsp_t        got;
    rsp_t        want;
    int unsigned r;
    if (rst_ni) begin
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        got.read_data       = m_axis_tdata_o[7:0];
        got.ext_int_flag    = m_axis_tdata_o[8];
        got.change_int_flag = m_axis_tdata_o[9];
        rsps_taken++;
        if (awaited_rsps.size() == 0) begin
          $display("%0t: unexpected result read_data=%h ext=%b chg=%b", $time,
                   got.read_data, got.ext_int_flag, got.change_int_flag);
          errors++;
        end else begin
          want = awaited_rsps.pop_front();
          if (got !== want) begin
            $display("%0t: mismatch expected read_data=%h ext=%b chg=%b, got read_data=%h ext=%b chg=%b",
                     $time, want.read_data, want.ext_int_flag, want.change_int_flag,
                     got.read_data, got.ext_int_flag, got.change_int_flag);
            errors++;
          end
        end
        // Hold off once for a long stretch so the block backs up
        if (!long_hold_done && rsps_taken >= 400) begin
          long_hold_done = 1'b1;
          hold_cnt = LongHold;
        end
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        m_axis_tready_i <= 1'b0;
      end else begin
        r = $urandom_range(0, 99);
        if ((rsps_taken / 170) % 4 != 1) begin
          if (r < 15) hold_cnt = $urandom_range(1, 3);
          else if (r < 17) hold_cnt = $urandom_range(10, 40);
        end
        m_axis_tready_i <= (hold_cnt == 0);
      end
    end
  end

  // Watchdog on cycles without any accepted request or result
  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic void push_req(logic [2:0] kind, logic [7:0] wdata, logic [2:0] idx,
                                   logic [7:0] levels);
    req_t r;
    r.req_type   = kind;
    r.wdata      = wdata;
    r.bit_index  = idx;
    r.pin_levels = levels;
    queued_reqs.push_back(r);
  endfunction

  function automatic void push_random_req();
    int unsigned r;
    logic [2:0]  kind;
    r = $urandom_range(0, 99);
    if (r < 18) kind = ReqPortWr;
    else if (r < 40) kind = ReqPortRd;
    else if (r < 52) kind = ReqDirWr;
    else if (r < 60) kind = ReqDirRd;
    else if (r < 95) kind = ReqPinEvt;
    else kind = 3'($urandom_range(5, 7));
    push_req(kind, 8'($urandom), 3'($urandom), 8'($urandom));
  endfunction

  // Wait until every request went out and every result came back
  task automatic wait_drained();
    while (queued_reqs.size() > 0 || s_axis_tvalid_i || awaited_rsps.size() > 0) begin
      @(posedge clk_i);
    end
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_port_cfg(logic [7:0] drive_mask, logic rise_edge);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= CfgDrivenPinMask;
    cfg_wdata_i <= drive_mask;
    @(posedge clk_i);
    cfg_idx_i   <= CfgIntEdgeRising;
    cfg_wdata_i <= {7'b0, rise_edge};
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    shadow_drive_mask = drive_mask;
    shadow_rise_edge  = rise_edge;
  endtask

  initial begin
    logic [7:0] mask;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: reset values, write masking, pin events, unused codes
    write_port_cfg(8'h00, 1'b1);
    push_req(ReqDirRd,  8'h00, 3'd0, 8'h00);
    push_req(ReqPortRd, 8'h00, 3'd0, 8'hff);
    push_req(ReqPortWr, 8'hff, 3'd0, 8'h00);
    push_req(ReqPinEvt, 8'h01, 3'd0, 8'h00);
    push_req(ReqPinEvt, 8'h00, 3'd0, 8'hff);
    push_req(ReqPinEvt, 8'hff, 3'd7, 8'h00);
    push_req(ReqPinEvt, 8'hfe, 3'd4, 8'h00);
    push_req(ReqDirWr,  8'h00, 3'd0, 8'h00);
    push_req(ReqDirRd,  8'hff, 3'd7, 8'hff);
    push_req(ReqPortWr, 8'ha5, 3'd0, 8'h00);
    push_req(ReqPortWr, 8'h5a, 3'd0, 8'h00);
    push_req(ReqDirWr,  8'h0f, 3'd0, 8'h00);
    push_req(ReqPortWr, 8'hff, 3'd0, 8'h00);
    push_req(3'd5, 8'hff, 3'd7, 8'hff);
    push_req(3'd6, 8'h00, 3'd0, 8'h00);
    push_req(3'd7, 8'h81, 3'd3, 8'h18);
    wait_drained();

    // Directed: all pins driven, falling edge selected
    write_port_cfg(8'hff, 1'b0);
    push_req(ReqPortRd, 8'h00, 3'd0, 8'h00);
    push_req(ReqPortRd, 8'h00, 3'd0, 8'hff);
    push_req(ReqPortRd, 8'h00, 3'd0, 8'h00);
    push_req(ReqPinEvt, 8'h01, 3'd0, 8'h00);
    push_req(ReqDirWr,  8'hff, 3'd0, 8'h00);
    push_req(ReqPortRd, 8'h00, 3'd0, 8'h00);
    push_req(ReqPortWr, 8'h3c, 3'd0, 8'hff);
    wait_drained();

    // Random phases over several port settings
    for (int p = 0; p < RandPhases; p++) begin
      case (p)
        0: mask = 8'hff;
        1: mask = 8'h00;
        default: mask = 8'($urandom);
      endcase
      write_port_cfg(mask, 1'(p % 2));
      for (int n = 0; n < PhaseItems; n++) push_random_req();
      wait_drained();
    end

    repeat (20) @(posedge clk_i);
    if (errors == 0 && awaited_rsps.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
